FILE: src/dtcf_pkg.sv
// ----------------------------------------------------------------------------
// dtcf_pkg
// Shared types and constants for the double to custom float converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dtcf_pkg;

    localparam int DBL_WIDTH      = 64;
    localparam int DBL_FRAC_BITS  = 52;
    localparam int DBL_EXP_BITS   = 11;
    localparam int DBL_BIAS       = 1023;

    localparam int TOTAL_W        = 7;
    localparam int EXP_W          = 6;
    localparam int CFG_DATA_W     = 7;
    localparam int CFG_IDX_W      = 1;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 7'd32;
    localparam logic [EXP_W-1:0]   EXP_RESET   = 6'd8;

    localparam logic [TOTAL_W-1:0] TOTAL_MIN   = 7'd3;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 7'd64;
    localparam logic [EXP_W-1:0]   EXP_MIN     = 6'd1;
    localparam logic [EXP_W-1:0]   EXP_MAX     = 6'd62;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOTAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXP   = 1'd1;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_bits;
        logic [EXP_W-1:0]   exp_bits;
        logic               bad;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/dtcf_cfg.sv
// ----------------------------------------------------------------------------
// dtcf_cfg
// Format registers and the bad-configuration decode.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcf_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dtcf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dtcf_pkg::CFG_DATA_W-1:0] cfg_data,
    output dtcf_pkg::cfg_t                      cfg
);
    import dtcf_pkg::*;

    logic [TOTAL_W-1:0] total_reg;
    logic [EXP_W-1:0]   exp_reg;
    logic               bad_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            exp_reg   <= EXP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_TOTAL: total_reg <= cfg_data;
                CFG_IDX_EXP:   exp_reg   <= cfg_data[EXP_W-1:0];
                default:       ;
            endcase
        end
    end

    // no fraction bit left when exp_bits + 1 >= total_bits
    always_comb
    begin
        bad_next = (total_reg < TOTAL_MIN) || (total_reg > TOTAL_MAX) ||
                   (exp_reg < EXP_MIN) || (exp_reg > EXP_MAX) ||
                   (({1'b0, exp_reg} + 7'd1) >= total_reg);
    end

    assign cfg.total_bits = total_reg;
    assign cfg.exp_bits   = exp_reg;
    assign cfg.bad        = bad_next;

endmodule

`default_nettype wire

FILE: src/dtcf_core.sv
// ----------------------------------------------------------------------------
// dtcf_core
// Input register, re-encode logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtcf_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [dtcf_pkg::DBL_WIDTH-1:0] double_bits,
    input  wire dtcf_pkg::cfg_t                cfg,
    output logic [dtcf_pkg::DBL_WIDTH-1:0]      result_bits,
    output logic                               bad_config,
    output logic                               done
);
    import dtcf_pkg::*;

    logic [DBL_WIDTH-1:0]     in_reg;
    logic                     v1_reg;
    logic [DBL_WIDTH-1:0]     result_reg;
    logic [DBL_WIDTH-1:0]     result_next;
    logic                     bad_reg;
    logic                     done_reg;

    logic                     sgn;
    logic [DBL_EXP_BITS-1:0]  dexp;
    logic [DBL_FRAC_BITS-1:0] frac;
    logic [TOTAL_W-1:0]       m;
    logic [DBL_WIDTH-1:0]     sign_pos;
    logic [DBL_WIDTH-2:0]     exp_all;
    logic [DBL_WIDTH-1:0]     inf_bits;
    logic [DBL_WIDTH-1:0]     bias;
    logic [DBL_WIDTH-1:0]     reb;
    logic [DBL_WIDTH-1:0]     frac64;
    logic [DBL_WIDTH-1:0]     tf;
    logic [DBL_WIDTH-1:0]     qnan;
    logic                     reb_neg;
    logic                     reb_ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_reg <= double_bits;
        end
        if (v1_reg)
        begin
            result_reg <= result_next;
            bad_reg    <= cfg.bad;
        end
    end

    always_comb
    begin
        sgn      = in_reg[DBL_WIDTH-1];
        dexp     = in_reg[DBL_WIDTH-2:DBL_FRAC_BITS];
        frac     = in_reg[DBL_FRAC_BITS-1:0];
        m        = cfg.total_bits - {1'b0, cfg.exp_bits} - 7'd1;
        sign_pos = {{(DBL_WIDTH-1){1'b0}}, sgn} << (cfg.total_bits - 7'd1);
        exp_all  = ({{(DBL_WIDTH-2){1'b0}}, 1'b1} << cfg.exp_bits) - 63'd1;
        inf_bits = {1'b0, exp_all} << m;
        bias     = {1'b0, ({{(DBL_WIDTH-2){1'b0}}, 1'b1} << (cfg.exp_bits - 6'd1)) - 63'd1};
        reb      = {{(DBL_WIDTH-DBL_EXP_BITS){1'b0}}, dexp} + bias - 64'(DBL_BIAS);
        reb_neg  = reb[DBL_WIDTH-1];
        reb_ovf  = !reb_neg && (reb[DBL_WIDTH-2:0] >= exp_all);
        frac64   = {{(DBL_WIDTH-DBL_FRAC_BITS){1'b0}}, frac};
        qnan     = {{(DBL_WIDTH-1){1'b0}}, 1'b1} << (m - 7'd1);

        if (m >= 7'(DBL_FRAC_BITS))
        begin
            tf = frac64 << (m - 7'(DBL_FRAC_BITS));
        end
        else
        begin
            tf = frac64 >> (7'(DBL_FRAC_BITS) - m);
        end

        if (cfg.bad)
        begin
            result_next = '0;
        end
        else if ((dexp == '0) && (frac == '0))
        begin
            result_next = sign_pos;
        end
        else if (dexp == '1)
        begin
            if (frac == '0)
            begin
                result_next = sign_pos | inf_bits;
            end
            else
            begin
                result_next = inf_bits | qnan;
            end
        end
        else if (reb_ovf)
        begin
            result_next = sign_pos | inf_bits;
        end
        else if (reb_neg)
        begin
            result_next = '0;
        end
        else
        begin
            result_next = sign_pos | (reb << m) | tf;
        end
    end

    assign result_bits = result_reg;
    assign bad_config  = bad_reg;
    assign done        = done_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##2 done)
        else $error("transaction did not complete two cycles after start");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(v1_reg))
        else $error("result strobe without a transaction in flight");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_config) |-> (result_bits == '0))
        else $error("bad configuration gave a nonzero result");

    a_upper_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !cfg.bad) |-> ((result_next >> cfg.total_bits) == '0))
        else $error("result has bits above the sign position");
`endif

endmodule

`default_nettype wire

FILE: src/double_to_custom_float_unit.sv
// ----------------------------------------------------------------------------
// double_to_custom_float_unit
// Re-encodes a binary64 bit pattern into a configurable custom float.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_we writes cfg_data into register cfg_index at a clock
//   edge (0 = total_bits, 1 = exp_bits). Write only while no transaction is
//   in flight.
//   Input: a transaction is taken at a clock edge with start high and busy
//   low. busy is tied low; a new value may be started every cycle.
//   Output: done is high for one cycle with result_bits and bad_config
//   valid, once the input register and then the result register have
//   loaded. One result per transaction, in order.
//   Registers: input register, result register; throughput one
//   transaction per cycle, set by the single conversion stage.
//   Reset: rst_n clears the in-flight strobes and loads total_bits = 32,
//   exp_bits = 8.
//   The receiver cannot stall; it must take each result on its done cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module double_to_custom_float_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dtcf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dtcf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [dtcf_pkg::DBL_WIDTH-1:0]  double_bits,
    output logic                                done,
    output logic [dtcf_pkg::DBL_WIDTH-1:0]       result_bits,
    output logic                                bad_config
);
    import dtcf_pkg::*;

    cfg_t cfg;

    dtcf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dtcf_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .double_bits (double_bits),
        .cfg         (cfg),
        .result_bits (result_bits),
        .bad_config  (bad_config),
        .done        (done)
    );

    assign busy = 1'b0;

endmodule

`default_nettype wire

FILE: tb/sv/dtcf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtcf_checker
// Watches the configuration, command and result ports of the double to
// custom float converter. It keeps its own copy of the format registers and
// works out each converted word when a transaction is accepted. Each result
// strobe is then compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------

module dtcf_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dtcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dtcf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              start,
    input  logic                              busy,
    input  logic [dtcf_pkg::DBL_WIDTH-1:0]    double_bits,
    input  logic                              done,
    input  logic [dtcf_pkg::DBL_WIDTH-1:0]    result_bits,
    input  logic                              bad_config,
    output int                                mismatch_count,
    output int                                pending
);

    import dtcf_pkg::*;

    typedef struct packed {
        logic [DBL_WIDTH-1:0] bits;
        logic                 bad;
    } conv_result_t;

    conv_result_t           conv_q[$];
    conv_result_t           want;
    logic [TOTAL_W-1:0]     fmt_total;
    logic [EXP_W-1:0]       fmt_exp;

    function automatic logic format_is_bad(input logic [TOTAL_W-1:0] t,
                                           input logic [EXP_W-1:0] e);
        return (t < TOTAL_MIN) || (t > TOTAL_MAX) || (e < EXP_MIN) || (e > EXP_MAX)
            || (int'(e) >= int'(t) - 1);
    endfunction

    function automatic logic [DBL_WIDTH-1:0] encode_custom(input logic [DBL_WIDTH-1:0] x,
                                                           input logic [TOTAL_W-1:0] t,
                                                           input logic [EXP_W-1:0] e);
        int                    m;
        logic                  sign;
        logic [10:0]           dexp;
        logic [51:0]           frac;
        logic [DBL_WIDTH-1:0]  sign_pos;
        logic [DBL_WIDTH-1:0]  exp_all;
        logic [DBL_WIDTH-1:0]  inf_bits;
        logic [DBL_WIDTH-1:0]  tf;
        longint                bias;
        longint                reb;
        m        = int'(t) - int'(e) - 1;
        sign     = x[63];
        dexp     = x[62:52];
        frac     = x[51:0];
        sign_pos = 64'(sign) << (int'(t) - 1);
        exp_all  = (64'd1 << e) - 64'd1;
        inf_bits = exp_all << m;
        if (dexp == 11'd0 && frac == 52'd0)
            return sign_pos;
        if (dexp == 11'h7FF)
        begin
            if (frac == 52'd0)
                return sign_pos | inf_bits;
            return inf_bits | (64'd1 << (m - 1));
        end
        bias = longint'((64'd1 << (int'(e) - 1)) - 64'd1);
        reb  = longint'({53'd0, dexp}) - DBL_BIAS + bias;
        if (reb >= longint'(exp_all))
            return sign_pos | inf_bits;
        if (reb < 0)
            return '0;
        if (m == DBL_FRAC_BITS)
            tf = {12'd0, frac};
        else if (m > DBL_FRAC_BITS)
            tf = {12'd0, frac} << (m - DBL_FRAC_BITS);
        else
            tf = {12'd0, frac} >> (DBL_FRAC_BITS - m);
        return sign_pos | (64'(reb) << m) | tf;
    endfunction

    function automatic conv_result_t convert_double(input logic [DBL_WIDTH-1:0] x,
                                                    input logic [TOTAL_W-1:0] t,
                                                    input logic [EXP_W-1:0] e);
        conv_result_t r;
        if (format_is_bad(t, e))
        begin
            r.bits = '0;
            r.bad  = 1'b1;
        end
        else
        begin
            r.bits = encode_custom(x, t, e);
            r.bad  = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_total      = TOTAL_RESET;
            fmt_exp        = EXP_RESET;
            conv_q.delete();
            mismatch_count = 0;
            pending        = 0;
        end
        else
        begin
            if (done)
            begin
                if (conv_q.size() == 0)
                begin
                    $error("unexpected result transaction: result_bits %h bad_config %b",
                           result_bits, bad_config);
                    mismatch_count++;
                end
                else
                begin
                    want = conv_q.pop_front();
                    if (result_bits !== want.bits)
                    begin
                        $error("result_bits mismatch: expected %h, actual %h",
                               want.bits, result_bits);
                        mismatch_count++;
                    end
                    if (bad_config !== want.bad)
                    begin
                        $error("bad_config mismatch: expected %b, actual %b",
                               want.bad, bad_config);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
                conv_q.push_back(convert_double(double_bits, fmt_total, fmt_exp));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IDX_TOTAL: fmt_total = cfg_data[TOTAL_W-1:0];
                    CFG_IDX_EXP:   fmt_exp   = cfg_data[EXP_W-1:0];
                    default:       ;
                endcase
            end
            pending = conv_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the double to custom float converter. A directed
// set of special values runs under the reset format, then the format is
// switched through extreme, invalid and random settings, each followed by
// random doubles biased toward specials and the exponent range edges.
// ----------------------------------------------------------------------------

module tb_top;

    import dtcf_pkg::*;

    localparam int ITEM_TARGET = 700;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_IDX_TOTAL;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [DBL_WIDTH-1:0]   double_bits = '0;
    logic                   done;
    logic [DBL_WIDTH-1:0]   result_bits;
    logic                   bad_config;
    int                     mismatch_count;
    int                     pending;

    int                     cur_total;
    int                     cur_exp;
    logic                   idle_on;
    int                     items_sent;

    logic [DBL_WIDTH-1:0]   special_vals[] = '{
        64'h0000000000000000, 64'h8000000000000000, 64'h7FF0000000000000,
        64'hFFF0000000000000, 64'h7FF8000000000000, 64'h7FF0000000000001,
        64'hFFF8000000000001, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000001,
        64'h800FFFFFFFFFFFFF, 64'h0010000000000000, 64'h7FEFFFFFFFFFFFFF,
        64'h3FF0000000000000, 64'hBFF0000000000000, 64'h3FF8000000000000,
        64'h47EFFFFFE0000000, 64'h47F0000000000000, 64'hC7F0000000000000,
        64'h3810000000000000, 64'h3800000000000000, 64'h37F0000000000000,
        64'hB7F0000000000000
    };

    int ext_total[] = '{64, 64, 64, 3, 64, 16, 10, 2, 65, 127, 32, 32, 10, 0};
    int ext_exp[]   = '{11, 62,  1, 1, 52,  5,  3, 1,  8, 127,  0, 63,  9, 0};

    double_to_custom_float_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .double_bits (double_bits),
        .done        (done),
        .result_bits (result_bits),
        .bad_config  (bad_config)
    );

    dtcf_checker u_conv_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .double_bits    (double_bits),
        .done           (done),
        .result_bits    (result_bits),
        .bad_config     (bad_config),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [DBL_WIDTH-1:0] random_double(input int t, input int e);
        logic [DBL_WIDTH-1:0] r;
        logic                 sign;
        logic [51:0]          frac;
        longint               base;
        longint               exp_all;
        longint               dexp;
        int                   pick;
        r    = {$urandom(), $urandom()};
        sign = r[63];
        frac = 52'({$urandom(), $urandom()});
        if ($urandom_range(0, 1) == 0)
            frac = (frac == '0) ? 52'd1 : frac;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return {sign, 11'd0, 52'd0};
                1:       return {sign, 11'h7FF, 52'd0};
                2:       return {sign, 11'h7FF, frac | 52'd1};
                default: return {sign, 11'd0, frac};
            endcase
        end
        if (pick <= 4 && e >= 1 && e <= 62)
        begin
            base    = longint'(DBL_BIAS) - ((longint'(1) << (e - 1)) - 1);
            exp_all = (longint'(1) << e) - 1;
            case ($urandom_range(0, 2))
                0:       dexp = base + $urandom_range(0, 6) - 3;
                1:       dexp = base + exp_all + $urandom_range(0, 6) - 3;
                default: dexp = base + $urandom_range(0, 200);
            endcase
            if (dexp < 0)
                dexp = 0;
            if (dexp > 2047)
                dexp = 2047;
            return {sign, dexp[10:0], frac};
        end
        return r;
    endfunction

    task automatic send_double(input logic [DBL_WIDTH-1:0] x);
        int gap;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        double_bits <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_format(input int t, input int e);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_TOTAL;
        cfg_data  <= t[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_IDX_EXP;
        cfg_data  <= e[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        cur_total = t & 'h7F;
        cur_exp   = e & 'h3F;
    endtask

    task automatic run_format(input int t, input int e, input int n);
        drain_results();
        write_format(t, e);
        idle_on = ($urandom_range(0, 3) != 0);
        repeat (n) send_double(random_double(cur_total, cur_exp));
    endtask

    initial
    begin
        int t;
        int e;
        cur_total  = int'(TOTAL_RESET);
        cur_exp    = int'(EXP_RESET);
        idle_on    = 1'b1;
        items_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (special_vals[i])
            send_double(special_vals[i]);

        foreach (ext_total[i])
            run_format(ext_total[i], ext_exp[i], 20);

        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                t = $urandom_range(0, 127);
                e = $urandom_range(0, 127);
            end
            else
            begin
                t = $urandom_range(3, 64);
                e = $urandom_range(1, (t - 2 < 62) ? t - 2 : 62);
            end
            run_format(t, e, $urandom_range(10, 30));
        end

        drain_results();
        repeat (5) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
